FILE: hdl/acs_pkg.sv
// Shared types, codes and constants of the converter channel-cycling sequencer.
package acs_pkg;

   // Field widths
   localparam int FUNC_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int CHAN_W    = 3;
   localparam int SAMPLE_W  = 24;
   localparam int SLOT_W    = 2;
   localparam int COUNT_W   = 16;
   localparam int KIND_W    = 3;
   localparam int ITER_W    = 18;
   localparam int STEP_W    = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Largest usable samples_per_channel
   localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'hFFFF;

   // Request functions
   localparam logic [FUNC_W-1:0] FUNC_START     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DRDY      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_DATA = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FAIL      = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_FIRST_CHANNEL  = 2'd0;
   localparam logic [1:0] REG_SECOND_CHANNEL = 2'd1;
   localparam logic [1:0] REG_THIRD_CHANNEL  = 2'd2;
   localparam logic [1:0] REG_SAMPLES        = 2'd3;

   // Converter command bytes
   localparam logic [BYTE_W-1:0] OP_WRITE_REG   = 8'h50;
   localparam logic [BYTE_W-1:0] REG_MUX_ADDR   = 8'h01;
   localparam logic [BYTE_W-1:0] OP_WRITE_MUX   = OP_WRITE_REG | REG_MUX_ADDR;
   localparam logic [BYTE_W-1:0] OP_WRITE_COUNT = 8'h00;
   localparam logic [BYTE_W-1:0] OP_RESYNC      = 8'hFC;
   localparam logic [BYTE_W-1:0] OP_RESUME      = 8'h00;
   localparam logic [BYTE_W-1:0] OP_READ_SAMPLE = 8'h01;
   localparam logic [BYTE_W-1:0] OP_CLOCK       = 8'h00;
   localparam logic [BYTE_W-1:0] MUX_NEG_COM    = 8'h08;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TX     = 3'd0,
      KIND_GAP11  = 3'd1,
      KIND_GAP6   = 3'd2,
      KIND_SAMPLE = 3'd3,
      KIND_DONE   = 3'd4
   } kind_type;

   // Result sequences handed to the emitter
   typedef enum logic [2:0] {
      MODE_PRIME       = 3'd0,
      MODE_RUN         = 3'd1,
      MODE_SAMPLE      = 3'd2,
      MODE_SAMPLE_DONE = 3'd3,
      MODE_DONE        = 3'd4,
      MODE_FAIL        = 3'd5
   } mode_type;

   typedef struct packed {
      mode_type                    mode;
      logic [BYTE_W-1:0]           mux_byte;
      logic signed [SAMPLE_W-1:0]  value;
      logic [SLOT_W-1:0]           slot;
      logic [COUNT_W-1:0]          number;
   } desc_type;

   // Emitter status towards the request side
   typedef struct packed {
      logic can_load;
   } emit_status_type;

   // Index of the final result of a sequence
   function automatic logic [STEP_W-1:0] last_step(input mode_type mode);
      case (mode)
         MODE_PRIME:       last_step = 4'd5;
         MODE_RUN:         last_step = 4'd10;
         MODE_SAMPLE_DONE: last_step = 4'd1;
         default:          last_step = 4'd0;
      endcase
   endfunction

endpackage

FILE: hdl/acs_req_if.sv
// Request channel of the sequencer: handshake and request fields.
interface acs_req_if;
   logic                        valid;
   logic                        ready;
   logic [acs_pkg::FUNC_W-1:0]  func;
   logic [acs_pkg::BYTE_W-1:0]  rx_high;
   logic [acs_pkg::BYTE_W-1:0]  rx_mid;
   logic [acs_pkg::BYTE_W-1:0]  rx_low;

   modport source (output valid, func, rx_high, rx_mid, rx_low, input ready);
   modport sink   (input valid, func, rx_high, rx_mid, rx_low, output ready);
endinterface

FILE: hdl/acs_rsp_if.sv
// Result channel of the sequencer: handshake and result fields.
interface acs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [acs_pkg::KIND_W-1:0]          kind;
   logic [acs_pkg::BYTE_W-1:0]          tx_byte;
   logic                                select_active;
   logic signed [acs_pkg::SAMPLE_W-1:0] sample_value;
   logic [acs_pkg::SLOT_W-1:0]          channel_slot;
   logic [acs_pkg::COUNT_W-1:0]         sample_number;
   logic                                failed;
   logic                                last;

   modport source (output valid, kind, tx_byte, select_active, sample_value, channel_slot,
                   sample_number, failed, last, input ready);
   modport sink   (input valid, kind, tx_byte, select_active, sample_value, channel_slot,
                   sample_number, failed, last, output ready);
endinterface

FILE: hdl/adc_channel_cycling_sequencer.sv
// Top level of the three-channel pipelined converter burst sequencer.
//
//   port      direction  carries
//   req_bus   in         func, rx_high, rx_mid, rx_low (valid/ready)
//   rsp_bus   out        kind, tx_byte, select_active, sample_value, channel_slot,
//                        sample_number, failed, last (valid/ready)
//   csr_*     in/out     APB-style register port, 32-bit data, 4-bit byte address
//
// A request is decoded in the cycle it is accepted; its results leave one per cycle
// from the emitter through the output register while rsp_bus is not stalled: 6 results
// for the first data-ready, 11 for later ones, 1 or 2 for read data.
// The next request is accepted in the cycle the previous one's final result is
// loaded into the output register; requests without results never occupy the emitter.
// Reset is synchronous; a stall on rsp_bus holds the emitter and then req_bus.ready.
module adc_channel_cycling_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   acs_req_if.sink                           req_bus,
   acs_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [acs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [acs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [acs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_PRIME = 4'b0010,
      PH_RUN   = 4'b0100,
      PH_READ  = 4'b1000
   } phase_type;

   // Configuration registers
   logic [acs_pkg::CHAN_W-1:0]  chan0_ff, chan1_ff, chan2_ff;
   logic [acs_pkg::COUNT_W-1:0] samples_ff;
   logic                        csr_write;
   logic [1:0]                  csr_index;

   // Burst state
   phase_type                   phase_ff, phase_in;
   logic [acs_pkg::ITER_W-1:0]  iter_ff, iter_in;
   logic [acs_pkg::SLOT_W-1:0]  next_slot_ff, next_slot_in;
   logic [acs_pkg::SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [acs_pkg::COUNT_W-1:0] sample_cnt_ff, sample_cnt_in;

   logic                        accept;
   logic                        load;
   acs_pkg::desc_type           desc;
   acs_pkg::emit_status_type    emit_status;

   logic [acs_pkg::COUNT_W-1:0] n_eff;
   logic [acs_pkg::ITER_W-1:0]  burst_span;
   logic [acs_pkg::ITER_W-1:0]  iter_inc;
   logic [acs_pkg::CHAN_W-1:0]  mux_chan;
   logic [acs_pkg::SLOT_W-1:0]  mux_slot;
   logic                        has_sample;
   logic                        burst_end;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         chan0_ff   <= 3'd0;
         chan1_ff   <= 3'd1;
         chan2_ff   <= 3'd2;
         samples_ff <= 16'd1;
      end else if (csr_write) begin
         case (csr_index)
            acs_pkg::REG_FIRST_CHANNEL:  chan0_ff   <= csr_pwdata[acs_pkg::CHAN_W-1:0];
            acs_pkg::REG_SECOND_CHANNEL: chan1_ff   <= csr_pwdata[acs_pkg::CHAN_W-1:0];
            acs_pkg::REG_THIRD_CHANNEL:  chan2_ff   <= csr_pwdata[acs_pkg::CHAN_W-1:0];
            acs_pkg::REG_SAMPLES:        samples_ff <= csr_pwdata[acs_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         acs_pkg::REG_FIRST_CHANNEL:  csr_prdata = {29'd0, chan0_ff};
         acs_pkg::REG_SECOND_CHANNEL: csr_prdata = {29'd0, chan1_ff};
         acs_pkg::REG_THIRD_CHANNEL:  csr_prdata = {29'd0, chan2_ff};
         acs_pkg::REG_SAMPLES:        csr_prdata = {16'd0, samples_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // Burst length: 3*N samples after the stale first read, N forced into 1..MAX_SAMPLES
   always_comb begin
      n_eff = samples_ff;
      if (n_eff == '0) begin
         n_eff = 16'd1;
      end
      if (n_eff > acs_pkg::MAX_SAMPLES) begin
         n_eff = acs_pkg::MAX_SAMPLES;
      end
   end
   assign burst_span = {2'b00, n_eff} + {1'b0, n_eff, 1'b0};
   assign iter_inc   = iter_ff + 18'd1;
   assign has_sample = (iter_ff != '0);
   assign burst_end  = (iter_inc > burst_span);

   // Multiplexer byte: priming always uses the first slot
   assign mux_slot = (phase_ff == PH_PRIME) ? 2'd0 : next_slot_ff;
   always_comb begin
      case (mux_slot)
         2'd0:    mux_chan = chan0_ff;
         2'd1:    mux_chan = chan1_ff;
         default: mux_chan = chan2_ff;
      endcase
   end

   assign req_bus.ready = emit_status.can_load;
   assign accept        = req_bus.valid && req_bus.ready;

   // Request decode and state update
   always_comb begin
      phase_in      = phase_ff;
      iter_in       = iter_ff;
      next_slot_in  = next_slot_ff;
      read_slot_in  = read_slot_ff;
      sample_cnt_in = sample_cnt_ff;
      load          = 1'b0;
      desc.mode     = acs_pkg::MODE_FAIL;
      desc.mux_byte = {1'b0, mux_chan, 4'd0} | acs_pkg::MUX_NEG_COM;
      desc.value    = {req_bus.rx_high, req_bus.rx_mid, req_bus.rx_low};
      desc.slot     = read_slot_ff;
      desc.number   = sample_cnt_ff;
      if (accept) begin
         case (req_bus.func)
            acs_pkg::FUNC_START: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in      = PH_PRIME;
                  iter_in       = '0;
                  next_slot_in  = 2'd0;
                  read_slot_in  = 2'd2;
                  sample_cnt_in = '0;
               end
            end
            acs_pkg::FUNC_DRDY: begin
               if (phase_ff == PH_PRIME) begin
                  load      = 1'b1;
                  desc.mode = acs_pkg::MODE_PRIME;
                  phase_in  = PH_RUN;
               end else if (phase_ff == PH_RUN) begin
                  load      = 1'b1;
                  desc.mode = acs_pkg::MODE_RUN;
                  phase_in  = PH_READ;
               end
            end
            acs_pkg::FUNC_READ_DATA: begin
               if (phase_ff == PH_READ) begin
                  // first read of a burst is stale and dropped
                  load = has_sample || burst_end;
                  if (has_sample && burst_end) begin
                     desc.mode = acs_pkg::MODE_SAMPLE_DONE;
                  end else if (has_sample) begin
                     desc.mode = acs_pkg::MODE_SAMPLE;
                  end else begin
                     desc.mode = acs_pkg::MODE_DONE;
                  end
                  if (has_sample && read_slot_ff == 2'd2) begin
                     sample_cnt_in = sample_cnt_ff + 16'd1;
                  end
                  iter_in      = iter_inc;
                  read_slot_in = (read_slot_ff == 2'd2) ? 2'd0 : read_slot_ff + 2'd1;
                  next_slot_in = (next_slot_ff == 2'd2) ? 2'd0 : next_slot_ff + 2'd1;
                  phase_in     = burst_end ? PH_IDLE : PH_RUN;
               end
            end
            default: begin
               if (phase_ff != PH_IDLE) begin
                  load      = 1'b1;
                  desc.mode = acs_pkg::MODE_FAIL;
                  phase_in  = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         iter_ff       <= '0;
         next_slot_ff  <= 2'd0;
         read_slot_ff  <= 2'd2;
         sample_cnt_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         iter_ff       <= iter_in;
         next_slot_ff  <= next_slot_in;
         read_slot_ff  <= read_slot_in;
         sample_cnt_ff <= sample_cnt_in;
      end
   end

   acs_emitter u_emitter (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .desc    (desc),
      .status  (emit_status),
      .rsp_bus (rsp_bus)
   );

   // Read slot always trails the queued multiplexer slot by one
   a_slot_pair: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff == ((read_slot_ff == 2'd2) ? 2'd0 : read_slot_ff + 2'd1))
      else $error("read slot and next slot out of step");

   // A failure request during a burst returns the block to idle
   a_fail_idles: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.func == acs_pkg::FUNC_FAIL && phase_ff != PH_IDLE)
      |=> phase_ff == PH_IDLE)
      else $error("failure did not end the burst");

   // Read data always leaves the reading phase
   a_read_leaves: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.func == acs_pkg::FUNC_READ_DATA && phase_ff == PH_READ)
      |=> (phase_ff == PH_RUN || phase_ff == PH_IDLE))
      else $error("read data left the block in the reading phase");

endmodule

FILE: hdl/acs_emitter.sv
// Result emitter: walks one result sequence into the registered result channel.
module acs_emitter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  acs_pkg::desc_type        desc,
   output acs_pkg::emit_status_type status,
   acs_rsp_if.source                rsp_bus
);

   // Sequence being walked
   acs_pkg::desc_type              cur_ff, cur_in;
   logic                           cur_valid_ff, cur_valid_in;
   logic [acs_pkg::STEP_W-1:0]     step_ff, step_in;

   // Output register
   logic                                rsp_valid_ff, rsp_valid_in;
   acs_pkg::kind_type                   kind_ff, kind_in;
   logic [acs_pkg::BYTE_W-1:0]          byte_ff, byte_in;
   logic                                sel_ff, sel_in;
   logic signed [acs_pkg::SAMPLE_W-1:0] val_ff, val_in;
   logic [acs_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   logic [acs_pkg::COUNT_W-1:0]         num_ff, num_in;
   logic                                fail_ff, fail_in;
   logic                                last_ff, last_in;

   logic out_free;
   logic emit;
   logic at_last;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = cur_valid_ff && out_free;
   assign at_last  = (step_ff == acs_pkg::last_step(cur_ff.mode));
   assign status.can_load = !cur_valid_ff || (emit && at_last);

   // Sequence position
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (load) begin
         cur_in       = desc;
         cur_valid_in = 1'b1;
         step_in      = '0;
      end else if (emit) begin
         if (at_last) begin
            cur_valid_in = 1'b0;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   // Result for the current step
   always_comb begin
      kind_in = acs_pkg::KIND_TX;
      byte_in = '0;
      sel_in  = 1'b1;
      val_in  = '0;
      slot_in = '0;
      num_in  = '0;
      fail_in = 1'b0;
      last_in = at_last;
      case (cur_ff.mode)
         acs_pkg::MODE_PRIME, acs_pkg::MODE_RUN: begin
            // mux write, SYNC, gap, WAKEUP, then (run mode only) RDATA, gap and clock bytes
            case (step_ff)
               4'd0:    byte_in = acs_pkg::OP_WRITE_MUX;
               4'd1:    byte_in = acs_pkg::OP_WRITE_COUNT;
               4'd2:    byte_in = cur_ff.mux_byte;
               4'd3:    byte_in = acs_pkg::OP_RESYNC;
               4'd4:    kind_in = acs_pkg::KIND_GAP11;
               4'd5:    byte_in = acs_pkg::OP_RESUME;
               4'd6:    byte_in = acs_pkg::OP_READ_SAMPLE;
               4'd7:    kind_in = acs_pkg::KIND_GAP6;
               default: byte_in = acs_pkg::OP_CLOCK;
            endcase
         end
         acs_pkg::MODE_SAMPLE, acs_pkg::MODE_SAMPLE_DONE: begin
            if (step_ff == '0) begin
               kind_in = acs_pkg::KIND_SAMPLE;
               val_in  = cur_ff.value;
               slot_in = cur_ff.slot;
               num_in  = cur_ff.number;
            end else begin
               kind_in = acs_pkg::KIND_DONE;
               sel_in  = 1'b0;
            end
         end
         acs_pkg::MODE_DONE: begin
            kind_in = acs_pkg::KIND_DONE;
            sel_in  = 1'b0;
         end
         acs_pkg::MODE_FAIL: begin
            kind_in = acs_pkg::KIND_DONE;
            sel_in  = 1'b0;
            fail_in = 1'b1;
         end
         default: begin
            kind_in = acs_pkg::KIND_DONE;
            sel_in  = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         sel_ff  <= sel_in;
         val_ff  <= val_in;
         slot_ff <= slot_in;
         num_ff  <= num_in;
         fail_ff <= fail_in;
         last_ff <= last_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = kind_ff;
   assign rsp_bus.tx_byte       = byte_ff;
   assign rsp_bus.select_active = sel_ff;
   assign rsp_bus.sample_value  = val_ff;
   assign rsp_bus.channel_slot  = slot_ff;
   assign rsp_bus.sample_number = num_ff;
   assign rsp_bus.failed        = fail_ff;
   assign rsp_bus.last          = last_ff;

   // Never step past the end of a sequence
   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> step_ff <= acs_pkg::last_step(cur_ff.mode))
      else $error("emitter step beyond end of sequence");

   // A new sequence is only loaded when the emitter is idle or the previous one is finishing
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> status.can_load)
      else $error("sequence loaded over a busy emitter");

   // The final result of a sequence carries the last flag
   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      (emit && at_last) |=> (rsp_valid_ff && last_ff))
      else $error("final result of a sequence without last flag");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the channel-cycling converter sequencer: directed and random bursts.
module testbench;

   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_STALL    = 300;

   typedef logic [acs_pkg::FUNC_W-1:0] func_type;

   // Burst phases as the sequencer sees them
   typedef enum logic [3:0] {
      SEQ_IDLE  = 4'b0001,
      SEQ_PRIME = 4'b0010,
      SEQ_RUN   = 4'b0100,
      SEQ_READ  = 4'b1000
   } seq_phase_type;

   typedef struct packed {
      acs_pkg::kind_type                    kind;
      logic [acs_pkg::BYTE_W-1:0]           tx_byte;
      logic                                 select_active;
      logic signed [acs_pkg::SAMPLE_W-1:0]  sample_value;
      logic [acs_pkg::SLOT_W-1:0]           channel_slot;
      logic [acs_pkg::COUNT_W-1:0]          sample_number;
      logic                                 failed;
      logic                                 last;
   } seq_result_type;

   // Stimulus plan: requests, register writes and pacing markers
   typedef enum logic [2:0] {
      STEP_REQUEST, STEP_REG_WRITE, STEP_SETTLE, STEP_LONG_STALL, STEP_STEADY
   } step_op_type;

   typedef struct {
      step_op_type  op;
      func_type     func;
      logic [23:0]  data;
      logic [1:0]   reg_index;
      logic [31:0]  value;
   } plan_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   acs_req_if req_bus ();
   acs_rsp_if rsp_bus ();

   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [acs_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [acs_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [acs_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   adc_channel_cycling_sequencer uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow configuration and burst state
   logic [acs_pkg::CHAN_W-1:0]  chan_sel [0:2] = '{3'd0, 3'd1, 3'd2};
   logic [acs_pkg::COUNT_W-1:0] samples_cfg = 16'd1;
   seq_phase_type               seq_phase = SEQ_IDLE;
   logic [acs_pkg::ITER_W-1:0]  iter_count = '0;
   logic [acs_pkg::SLOT_W-1:0]  next_slot = 2'd0;
   logic [acs_pkg::SLOT_W-1:0]  read_slot = 2'd2;
   logic [acs_pkg::COUNT_W-1:0] sample_count = '0;

   seq_result_type batch [0:10];
   int             batch_n;
   seq_result_type due_results [$];

   plan_step_type plan [$];
   plan_step_type cur_step;

   bit req_took = 1'b0;
   bit csr_took = 1'b0;
   bit settling = 1'b0;
   bit steady = 1'b0;
   bit stimulus_done = 1'b0;
   int pause_left = 0;
   int csr_stage = 0;
   int stalls_asked = 0;
   int stalls_served = 0;
   int stall_left = 0;
   int failures = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func = acs_pkg::FUNC_START;
      req_bus.rx_high = '0;
      req_bus.rx_mid = '0;
      req_bus.rx_low = '0;
      rsp_bus.ready = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   task automatic add_result(input acs_pkg::kind_type kind, input logic [7:0] tx,
                             input logic sel, input logic [23:0] val,
                             input logic [1:0] slot, input logic [15:0] num,
                             input logic fail);
      batch[batch_n] = '{kind, tx, sel, val, slot, num, fail, 1'b0};
      batch_n++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      add_result(acs_pkg::KIND_TX, b, 1'b1, '0, '0, '0, 1'b0);
   endtask

   function automatic logic [7:0] mux_setting(input logic [1:0] slot);
      logic [2:0] ch;
      ch = (slot == 2'd0) ? chan_sel[0] : (slot == 2'd1) ? chan_sel[1] : chan_sel[2];
      return {1'b0, ch, 4'h0} | acs_pkg::MUX_NEG_COM;
   endfunction

   // Multiplexer write for a slot, then SYNC, settling gap and WAKEUP
   task automatic retune(input logic [1:0] slot);
      send_byte(acs_pkg::OP_WRITE_MUX);
      send_byte(acs_pkg::OP_WRITE_COUNT);
      send_byte(mux_setting(slot));
      send_byte(acs_pkg::OP_RESYNC);
      add_result(acs_pkg::KIND_GAP11, '0, 1'b1, '0, '0, '0, 1'b0);
      send_byte(acs_pkg::OP_RESUME);
   endtask

   task automatic advance_sequencer(input func_type func, input logic [23:0] raw);
      logic [acs_pkg::ITER_W-1:0] span;
      // zero means one; 16 bits can never exceed the ceiling
      span = 18'd3 * ((samples_cfg == '0) ? 18'd1 : 18'(samples_cfg));
      batch_n = 0;
      case (func)
         acs_pkg::FUNC_START: begin
            if (seq_phase == SEQ_IDLE) begin
               seq_phase = SEQ_PRIME;
               iter_count = '0;
               next_slot = 2'd0;
               read_slot = 2'd2;
               sample_count = '0;
            end
         end
         acs_pkg::FUNC_DRDY: begin
            if (seq_phase == SEQ_PRIME) begin
               retune(2'd0);
               seq_phase = SEQ_RUN;
            end else if (seq_phase == SEQ_RUN) begin
               retune(next_slot);
               send_byte(acs_pkg::OP_READ_SAMPLE);
               add_result(acs_pkg::KIND_GAP6, '0, 1'b1, '0, '0, '0, 1'b0);
               send_byte(acs_pkg::OP_CLOCK);
               send_byte(acs_pkg::OP_CLOCK);
               send_byte(acs_pkg::OP_CLOCK);
               seq_phase = SEQ_READ;
            end
         end
         acs_pkg::FUNC_READ_DATA: begin
            if (seq_phase == SEQ_READ) begin
               // first read of a burst is stale
               if (iter_count != '0) begin
                  add_result(acs_pkg::KIND_SAMPLE, '0, 1'b1, raw, read_slot,
                             sample_count, 1'b0);
                  if (read_slot == 2'd2)
                     sample_count++;
               end
               iter_count++;
               read_slot = (read_slot == 2'd2) ? 2'd0 : read_slot + 2'd1;
               next_slot = (next_slot == 2'd2) ? 2'd0 : next_slot + 2'd1;
               seq_phase = SEQ_RUN;
               if (iter_count > span) begin
                  add_result(acs_pkg::KIND_DONE, '0, 1'b0, '0, '0, '0, 1'b0);
                  seq_phase = SEQ_IDLE;
               end
            end
         end
         acs_pkg::FUNC_FAIL: begin
            if (seq_phase != SEQ_IDLE) begin
               add_result(acs_pkg::KIND_DONE, '0, 1'b0, '0, '0, '0, 1'b1);
               seq_phase = SEQ_IDLE;
            end
         end
         default: ;
      endcase
      if (batch_n > 0)
         batch[batch_n-1].last = 1'b1;
      for (int i = 0; i < batch_n; i++)
         due_results.push_back(batch[i]);
   endtask

   // ---------------------------------------------------------------- monitor

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      seq_result_type want;
      req_took = 1'b0;
      csr_took = 1'b0;
      if (!reset) begin
         // register writes land in the shadow copy
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            csr_took = 1'b1;
            case (csr_paddr[3:2])
               acs_pkg::REG_FIRST_CHANNEL:  chan_sel[0] = csr_pwdata[2:0];
               acs_pkg::REG_SECOND_CHANNEL: chan_sel[1] = csr_pwdata[2:0];
               acs_pkg::REG_THIRD_CHANNEL:  chan_sel[2] = csr_pwdata[2:0];
               acs_pkg::REG_SAMPLES:        samples_cfg = csr_pwdata[15:0];
               default: ;
            endcase
         end
         // predict before checking, so a request's results are always queued first
         if (req_bus.valid && req_bus.ready) begin
            req_took = 1'b1;
            advance_sequencer(req_bus.func, {req_bus.rx_high, req_bus.rx_mid, req_bus.rx_low});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: result expected none got kind %0h byte %0h value %0h",
                        $time, rsp_bus.kind, rsp_bus.tx_byte, rsp_bus.sample_value);
               failures++;
            end else begin
               want = due_results.pop_front();
               compare_field("kind", 32'(want.kind), 32'(rsp_bus.kind));
               compare_field("tx_byte", 32'(want.tx_byte), 32'(rsp_bus.tx_byte));
               compare_field("select_active", 32'(want.select_active),
                             32'(rsp_bus.select_active));
               compare_field("sample_value", 32'(want.sample_value),
                             32'(rsp_bus.sample_value));
               compare_field("channel_slot", 32'(want.channel_slot),
                             32'(rsp_bus.channel_slot));
               compare_field("sample_number", 32'(want.sample_number),
                             32'(rsp_bus.sample_number));
               compare_field("failed", 32'(want.failed), 32'(rsp_bus.failed));
               compare_field("last", 32'(want.last), 32'(rsp_bus.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_took) begin
            req_bus.valid = 1'b0;
            if (!steady && $urandom_range(0, 4) == 0)
               pause_left = $urandom_range(1, 12);
         end
         if (!req_bus.valid) begin
            if (pause_left > 0) begin
               pause_left--;
            end else if (csr_stage == 1) begin
               csr_penable = 1'b1;
               csr_stage = 2;
            end else if (csr_stage == 2) begin
               if (csr_took) begin
                  csr_psel = 1'b0;
                  csr_penable = 1'b0;
                  csr_pwrite = 1'b0;
                  csr_stage = 0;
               end
            end else if (settling) begin
               // hold back until the block has delivered everything
               if (due_results.size() == 0) begin
                  settling = 1'b0;
                  pause_left = SETTLE_CYCLES;
               end
            end else if (plan.size() > 0) begin
               cur_step = plan.pop_front();
               case (cur_step.op)
                  STEP_REQUEST: begin
                     req_bus.func = cur_step.func;
                     req_bus.rx_high = cur_step.data[23:16];
                     req_bus.rx_mid = cur_step.data[15:8];
                     req_bus.rx_low = cur_step.data[7:0];
                     req_bus.valid = 1'b1;
                  end
                  STEP_REG_WRITE: begin
                     csr_psel = 1'b1;
                     csr_pwrite = 1'b1;
                     csr_paddr = {cur_step.reg_index, 2'b00};
                     csr_pwdata = cur_step.value;
                     csr_stage = 1;
                  end
                  STEP_SETTLE:     settling = 1'b1;
                  STEP_LONG_STALL: stalls_asked++;
                  STEP_STEADY:     steady = 1'b1;
                  default: ;
               endcase
            end else begin
               stimulus_done = 1'b1;
            end
         end
      end
   end

   // Result side back-pressure: random bursts, plus one long hold on request
   always @(negedge clock) begin
      if (stalls_served != stalls_asked) begin
         stalls_served = stalls_asked;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready = 1'b0;
         stall_left = $urandom_range(0, 11);
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic plan_request(input func_type func, input logic [23:0] data);
      plan.push_back('{STEP_REQUEST, func, data, 2'd0, 32'd0});
   endtask

   task automatic plan_marker(input step_op_type op);
      plan.push_back('{op, acs_pkg::FUNC_START, 24'd0, 2'd0, 32'd0});
   endtask

   // Drop any open burst, wait for the block to go quiet, then reprogram it
   task automatic plan_settings(input logic [2:0] c0, input logic [2:0] c1,
                                input logic [2:0] c2, input logic [15:0] n);
      plan_request(acs_pkg::FUNC_FAIL, '0);
      plan_marker(STEP_SETTLE);
      plan.push_back('{STEP_REG_WRITE, acs_pkg::FUNC_START, 24'd0,
                       acs_pkg::REG_FIRST_CHANNEL, 32'(c0)});
      plan.push_back('{STEP_REG_WRITE, acs_pkg::FUNC_START, 24'd0,
                       acs_pkg::REG_SECOND_CHANNEL, 32'(c1)});
      plan.push_back('{STEP_REG_WRITE, acs_pkg::FUNC_START, 24'd0,
                       acs_pkg::REG_THIRD_CHANNEL, 32'(c2)});
      plan.push_back('{STEP_REG_WRITE, acs_pkg::FUNC_START, 24'd0,
                       acs_pkg::REG_SAMPLES, 32'(n)});
   endtask

   // Well-formed burst with random data, the odd stray request, optionally cut short
   task automatic plan_burst(input int reads, input bit cut);
      plan_request(acs_pkg::FUNC_START, '0);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      for (int r = 0; r < reads; r++) begin
         if ($urandom_range(0, 11) == 0)
            plan_request(func_type'($urandom_range(0, 3)), 24'($urandom));
         plan_request(acs_pkg::FUNC_DRDY, '0);
         plan_request(acs_pkg::FUNC_READ_DATA, 24'($urandom));
      end
      if (cut)
         plan_request(acs_pkg::FUNC_FAIL, '0);
   endtask

   initial begin
      // stray requests while idle are dropped
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_READ_DATA, 24'h123456);
      plan_request(acs_pkg::FUNC_FAIL, '0);
      // start twice, read data during priming, then prime
      plan_request(acs_pkg::FUNC_START, '0);
      plan_request(acs_pkg::FUNC_START, '0);
      plan_request(acs_pkg::FUNC_READ_DATA, 24'hFFFFFF);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      // data-ready to run, then data-ready while reading and start while busy are dropped
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_START, '0);
      // stale first read, then the value extremes and the natural end of the burst
      plan_request(acs_pkg::FUNC_READ_DATA, 24'hFFFFFF);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_READ_DATA, 24'h800000);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_READ_DATA, 24'h7FFFFF);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_READ_DATA, 24'h000000);
      // failure while priming, running and reading
      plan_request(acs_pkg::FUNC_START, '0);
      plan_request(acs_pkg::FUNC_FAIL, '0);
      plan_request(acs_pkg::FUNC_START, '0);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_FAIL, '0);
      plan_request(acs_pkg::FUNC_START, '0);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_DRDY, '0);
      plan_request(acs_pkg::FUNC_FAIL, '0);

      // zero samples per channel behaves as one
      plan_settings(3'd7, 3'd0, 3'd5, 16'd0);
      for (int b = 0; b < 5; b++)
         plan_burst(4, $urandom_range(0, 3) == 0);

      // two per channel, with a long hold on the result side
      plan_settings(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), 16'd2);
      plan_marker(STEP_LONG_STALL);
      for (int b = 0; b < 4; b++)
         plan_burst(7, 1'b0);

      // largest count: bursts only ever end by failure
      plan_settings(3'd0, 3'd7, 3'd7, 16'hFFFF);
      for (int b = 0; b < 3; b++)
         plan_burst($urandom_range(3, 9), 1'b1);

      // final stretch without idling on either side
      plan_settings(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), 16'd1);
      plan_marker(STEP_STEADY);
      for (int b = 0; b < 4; b++)
         plan_burst(4, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!(stimulus_done && due_results.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
hdl/acs_pkg.sv
hdl/acs_req_if.sv
hdl/acs_rsp_if.sv
hdl/acs_emitter.sv
hdl/adc_channel_cycling_sequencer.sv
bench/testbench.sv
